/* rtl/core/rdm_pkg.sv */
// ----------------------------------------------------------------------------
// rdm_pkg
// Shared types and constants for the radial distortion mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package rdm_pkg;

  localparam int NUM_COEFFS   = 6;
  localparam int RADIUS_SHIFT = 11;
  localparam int COEFF_REGS   = 6;
  localparam int HSHIFT       = 4 + RADIUS_SHIFT;
  localparam int SQRT_STAGES  = 17;
  localparam int HORNER_STAGES = 2 * NUM_COEFFS;

  localparam logic signed [31:0] COEFF_ONE   = 32'sh1000_0000;
  localparam logic signed [50:0] HRND        = 51'sd1 <<< (HSHIFT - 1);
  localparam logic signed [51:0] ACC_MAX     = 52'sd2147483647;
  localparam logic signed [51:0] ACC_MIN     = -52'sd2147483648;
  localparam logic signed [49:0] ORND        = 50'sd1 <<< 27;
  localparam logic signed [22:0] COORD_MAX   = 23'sd32767;
  localparam logic signed [22:0] COORD_MIN   = -23'sd32768;

  typedef enum logic [2:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_COEFF_0  = 3'd2,
    REG_COEFF_1  = 3'd3,
    REG_COEFF_2  = 3'd4,
    REG_COEFF_3  = 3'd5,
    REG_COEFF_4  = 3'd6,
    REG_COEFF_5  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0]              center_x;
    logic signed [15:0]              center_y;
    logic [COEFF_REGS-1:0][31:0]     coeff;
  } cfg_t;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } dd_t;

  typedef struct packed {
    dd_t         d;
    logic [33:0] n;
  } fr_t;

  typedef struct packed {
    dd_t         d;
    logic [33:0] n;
    logic [19:0] rem;
    logic [16:0] root;
  } sq_t;

  typedef struct packed {
    dd_t         d;
    logic [16:0] r;
  } rd_t;

  typedef struct packed {
    dd_t                d;
    logic [16:0]        r;
    logic signed [31:0] acc;
    logic signed [49:0] prod;
  } hn_t;

  typedef struct packed {
    dd_t                d;
    logic signed [31:0] acc;
  } ga_t;

  typedef struct packed {
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic               saturated;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/rdm_if.sv */
// ----------------------------------------------------------------------------
// rdm_in_if / rdm_out_if
// Valid/ready channels for coordinates in and mapped coordinates out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_in;
  logic signed [15:0] y_in;
  modport source (output valid, x_in, y_in, input ready);
  modport sink   (input valid, x_in, y_in, output ready);
endinterface

interface rdm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_out;
  logic signed [15:0] y_out;
  logic               saturated;
  modport source (output valid, x_out, y_out, saturated, input ready);
  modport sink   (input valid, x_out, y_out, saturated, output ready);
endinterface

`default_nettype wire

/* rtl/core/rdm_front.sv */
// ----------------------------------------------------------------------------
// rdm_front
// Center offsets, squares and squared radius, three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rdm_pkg::cfg_t        cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [15:0]   in_x,
  input  wire logic signed [15:0]   in_y,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rdm_pkg::fr_t              out_data
);

  logic [2:0]         v_r;
  logic [3:0]         en;
  rdm_pkg::dd_t       d0_r, d1_r;
  logic [31:0]        sqx_r, sqy_r;
  rdm_pkg::fr_t       fr_r;
  logic signed [33:0] px, py;

  assign en[3] = out_ready;
  assign en[2] = !v_r[2] || en[3];
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign in_ready = en[0];

  assign px = d0_r.dx * d0_r.dx;
  assign py = d0_r.dy * d0_r.dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
    if (en[0]) begin
      d0_r.dx <= $signed({in_x[15], in_x}) - $signed({cfg.center_x[15], cfg.center_x});
      d0_r.dy <= $signed({in_y[15], in_y}) - $signed({cfg.center_y[15], cfg.center_y});
    end
    if (en[1]) begin
      d1_r  <= d0_r;
      sqx_r <= px[31:0];
      sqy_r <= py[31:0];
    end
    if (en[2]) begin
      fr_r.d <= d1_r;
      fr_r.n <= {2'b00, sqx_r} + {2'b00, sqy_r};
    end
  end

  assign out_valid = v_r[2];
  assign out_data  = fr_r;

endmodule

`default_nettype wire

/* rtl/core/rdm_sqrt.sv */
// ----------------------------------------------------------------------------
// rdm_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_sqrt (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rdm_pkg::fr_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rdm_pkg::rd_t       out_data
);

  localparam int NS = rdm_pkg::SQRT_STAGES;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;
  rdm_pkg::sq_t  st_r  [NS];
  rdm_pkg::sq_t  st_nxt[NS];

  assign en[NS]   = out_ready;
  assign in_ready = en[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int B = NS - 1 - k;
    rdm_pkg::sq_t src;
    logic [21:0]  tmp;
    logic [21:0]  trial;

    assign en[k] = !v_r[k] || en[k+1];

    if (k == 0) begin : g_first
      assign src = '{d: in_data.d, n: in_data.n, rem: '0, root: '0};
    end else begin : g_next
      assign src = st_r[k-1];
    end

    assign tmp   = {src.rem, src.n[2*B+1 -: 2]};
    assign trial = {3'b000, src.root, 2'b01};

    always_comb begin
      st_nxt[k]   = src;
      if (tmp >= trial) begin
        st_nxt[k].rem  = 20'(tmp - trial);
        st_nxt[k].root = {src.root[15:0], 1'b1};
      end else begin
        st_nxt[k].rem  = tmp[19:0];
        st_nxt[k].root = {src.root[15:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1];
      end
      if (en[k]) st_r[k] <= st_nxt[k];
    end
  end

  assign out_valid  = v_r[NS-1];
  assign out_data.d = st_r[NS-1].d;
  assign out_data.r = st_r[NS-1].root;

endmodule

`default_nettype wire

/* rtl/core/rdm_horner.sv */
// ----------------------------------------------------------------------------
// rdm_horner
// Gain polynomial by Horner's rule: multiply stage, then round/add/clip stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_horner (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rdm_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rdm_pkg::rd_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rdm_pkg::ga_t       out_data
);

  localparam int NS = rdm_pkg::HORNER_STAGES;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;
  rdm_pkg::hn_t  st_r  [NS];
  rdm_pkg::hn_t  st_nxt[NS];

  assign en[NS]   = out_ready;
  assign in_ready = en[0];

  for (genvar j = 0; j < rdm_pkg::NUM_COEFFS; j++) begin : g_step
    localparam int CI = rdm_pkg::NUM_COEFFS - 1 - j;
    rdm_pkg::hn_t       src;
    logic signed [50:0] rs;
    logic signed [51:0] sum;
    logic signed [31:0] c;

    if (j == 0) begin : g_first
      assign src = '{d: in_data.d, r: in_data.r, acc: '0, prod: '0};
    end else begin : g_next
      assign src = st_r[2*j-1];
    end

    assign c   = $signed(cfg.coeff[CI]);
    assign rs  = ($signed({st_r[2*j].prod[49], st_r[2*j].prod}) + rdm_pkg::HRND)
                 >>> rdm_pkg::HSHIFT;
    assign sum = $signed({{20{c[31]}}, c}) + $signed({rs[50], rs});

    always_comb begin
      st_nxt[2*j]      = src;
      st_nxt[2*j].prod = src.acc * $signed({1'b0, src.r});
      st_nxt[2*j+1]    = st_r[2*j];
      if (sum > rdm_pkg::ACC_MAX) begin
        st_nxt[2*j+1].acc = rdm_pkg::ACC_MAX[31:0];
      end else if (sum < rdm_pkg::ACC_MIN) begin
        st_nxt[2*j+1].acc = rdm_pkg::ACC_MIN[31:0];
      end else begin
        st_nxt[2*j+1].acc = sum[31:0];
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_ctl
    assign en[k] = !v_r[k] || en[k+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1];
      end
      if (en[k]) st_r[k] <= st_nxt[k];
    end
  end

  assign out_valid    = v_r[NS-1];
  assign out_data.d   = st_r[NS-1].d;
  assign out_data.acc = st_r[NS-1].acc;

endmodule

`default_nettype wire

/* rtl/core/rdm_out.sv */
// ----------------------------------------------------------------------------
// rdm_out
// Offset scaling, rounding, center add-back and saturation; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdm_out (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rdm_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rdm_pkg::ga_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rdm_pkg::res_t      out_data
);

  logic [1:0]         v_r;
  logic [2:0]         en;
  logic signed [48:0] px_r, py_r;
  rdm_pkg::res_t      res_r, res_nxt;
  logic signed [49:0] qx, qy;
  logic signed [22:0] ox, oy;
  logic               hx, hy;

  assign en[2] = out_ready;
  assign en[1] = !v_r[1] || en[2];
  assign en[0] = !v_r[0] || en[1];
  assign in_ready = en[0];

  assign qx = ($signed({px_r[48], px_r}) + rdm_pkg::ORND) >>> 28;
  assign qy = ($signed({py_r[48], py_r}) + rdm_pkg::ORND) >>> 28;
  assign ox = $signed(qx[22:0]) + $signed({{7{cfg.center_x[15]}}, cfg.center_x});
  assign oy = $signed(qy[22:0]) + $signed({{7{cfg.center_y[15]}}, cfg.center_y});

  always_comb begin
    hx = 1'b1;
    hy = 1'b1;
    if (ox > rdm_pkg::COORD_MAX) begin
      res_nxt.x_out = rdm_pkg::COORD_MAX[15:0];
    end else if (ox < rdm_pkg::COORD_MIN) begin
      res_nxt.x_out = rdm_pkg::COORD_MIN[15:0];
    end else begin
      res_nxt.x_out = ox[15:0];
      hx = 1'b0;
    end
    if (oy > rdm_pkg::COORD_MAX) begin
      res_nxt.y_out = rdm_pkg::COORD_MAX[15:0];
    end else if (oy < rdm_pkg::COORD_MIN) begin
      res_nxt.y_out = rdm_pkg::COORD_MIN[15:0];
    end else begin
      res_nxt.y_out = oy[15:0];
      hy = 1'b0;
    end
    res_nxt.saturated = hx || hy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
    if (en[0]) begin
      px_r <= in_data.d.dx * in_data.acc;
      py_r <= in_data.d.dy * in_data.acc;
    end
    if (en[1]) res_r <= res_nxt;
  end

  assign out_valid = v_r[1];
  assign out_data  = res_r;

endmodule

`default_nettype wire

/* rtl/core/radial_distortion_map.sv */
// ----------------------------------------------------------------------------
// radial_distortion_map
// Radial lens distortion remap of Q12.4 coordinates, fully pipelined.
// ----------------------------------------------------------------------------
//  port     dir  handshake    transaction
//  in_ch    in   valid/ready  x_in, y_in
//  out_ch   out  valid/ready  x_out, y_out, saturated
//  cfg_*    in   APB          8 registers at 4*i
//
//  One transaction per cycle in while out_ch is not stalled; the path runs
//  through the front stages, the one-bit-per-stage square root, the two
//  stages per Horner step and the output stages.
//  Synchronous active-low reset clears all stage valids and loads the
//  register reset values. Each stage holds while its successor is full and
//  stalled, so bubbles close up and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_distortion_map (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rdm_in_if.sink           in_ch,
  rdm_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  rdm_pkg::cfg_t     cfg_r;
  rdm_pkg::reg_idx_t idx;
  logic              wr;

  logic          f_valid, f_ready, s_valid, s_ready, h_valid, h_ready;
  rdm_pkg::fr_t  f_data;
  rdm_pkg::rd_t  s_data;
  rdm_pkg::ga_t  h_data;
  rdm_pkg::res_t o_data;

  assign idx        = rdm_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x <= '0;
      cfg_r.center_y <= '0;
      cfg_r.coeff[rdm_pkg::COEFF_REGS-1:1] <= '0;
      cfg_r.coeff[0] <= rdm_pkg::COEFF_ONE;
    end else if (wr) begin
      unique case (idx)
        rdm_pkg::REG_CENTER_X: cfg_r.center_x <= cfg_pwdata[15:0];
        rdm_pkg::REG_CENTER_Y: cfg_r.center_y <= cfg_pwdata[15:0];
        default: cfg_r.coeff[3'(idx - rdm_pkg::REG_COEFF_0)] <= cfg_pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rdm_pkg::REG_CENTER_X: cfg_prdata = {{16{cfg_r.center_x[15]}}, cfg_r.center_x};
      rdm_pkg::REG_CENTER_Y: cfg_prdata = {{16{cfg_r.center_y[15]}}, cfg_r.center_y};
      default:               cfg_prdata = cfg_r.coeff[3'(idx - rdm_pkg::REG_COEFF_0)];
    endcase
  end

  rdm_front u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_x(in_ch.x_in), .in_y(in_ch.y_in),
    .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
  );

  rdm_sqrt u_sqrt (
    .clk, .rst_n,
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(s_valid), .out_ready(s_ready), .out_data(s_data)
  );

  rdm_horner u_horner (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(s_valid), .in_ready(s_ready), .in_data(s_data),
    .out_valid(h_valid), .out_ready(h_ready), .out_data(h_data)
  );

  rdm_out u_out (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid(h_valid), .in_ready(h_ready), .in_data(h_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(o_data)
  );

  assign out_ch.x_out     = o_data.x_out;
  assign out_ch.y_out     = o_data.y_out;
  assign out_ch.saturated = o_data.saturated;

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |->
      (out_ch.x_out == 16'sh7fff) || (out_ch.x_out == -16'sh8000) ||
      (out_ch.y_out == 16'sh7fff) || (out_ch.y_out == -16'sh8000))
    else $error("saturated flag without clipped coordinate");

  a_cx_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr && (idx == rdm_pkg::REG_CENTER_X) |=> cfg_r.center_x == $past(cfg_pwdata[15:0]))
    else $error("center_x write lost");

  a_coeff0_reset: assert property (@(posedge clk)
    !rst_n |=> cfg_r.coeff[0] == rdm_pkg::COEFF_ONE)
    else $error("coeff_0 reset value wrong");

endmodule

`default_nettype wire
